// File: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/erv_pkg.sv
// shared types and constants of the energy ratio voice detector
`default_nettype none
package erv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 18;
    localparam int MAG_W    = 16;
    localparam int TOTAL_W  = 36;
    localparam int ALPHA_W  = 16;
    localparam int RATIO_W  = 16;
    localparam int WLEN_W   = 15;
    localparam int PROD_W   = FILT_W + 1 + ALPHA_W + 1;
    localparam int FRAC_W   = 16;

    localparam int FILT_MAX = 131071;
    localparam int FILT_MIN = -131072;
    localparam int MAG_MAX  = 65535;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ENERGY_RATIO  = 2'd3;

    localparam logic               RST_FILTER_ENABLE = 1'b1;
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA  = 16'd2478;
    localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH = 15'd16000;
    localparam logic [RATIO_W-1:0] RST_ENERGY_RATIO  = 16'd154;

    typedef struct packed {
        logic               filter_enable;
        logic [ALPHA_W-1:0] filter_alpha;
        logic [WLEN_W-1:0]  window_length;
        logic [RATIO_W-1:0] energy_ratio;
    } cfg_t;

    typedef struct packed {
        logic load;      // sample beat taken, ring read issued
        logic filt;      // filter multiply, drop oldest ring entry
        logic acc;       // round, magnitude, sums, ring write
        logic ev_mul;    // first products of the decision
        logic ev_scale;  // scale by window length
        logic finish;    // write result, clear buffer state
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/erv_if.sv
// sample and result stream interfaces
`default_nettype none
interface erv_in_if import erv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       last_sample;

    modport source (output valid, output audio_sample, output last_sample, input ready);
    modport sink (input valid, input audio_sample, input last_sample, output ready);
endinterface

interface erv_out_if ();
    logic valid;
    logic ready;
    logic voice_active;
    logic buffer_long_enough;

    modport source (output valid, output voice_active, output buffer_long_enough, input ready);
    modport sink (input valid, input voice_active, input buffer_long_enough, output ready);
endinterface
`default_nettype wire

// File: rtl/erv_regs.sv
// apb configuration registers
`default_nettype none
module erv_regs import erv_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable <= RST_FILTER_ENABLE;
            cfg_reg.filter_alpha  <= RST_FILTER_ALPHA;
            cfg_reg.window_length <= RST_WINDOW_LENGTH;
            cfg_reg.energy_ratio  <= RST_ENERGY_RATIO;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FILTER_ENABLE: cfg_reg.filter_enable <= pwdata[0];
                REG_FILTER_ALPHA:  cfg_reg.filter_alpha  <= pwdata[ALPHA_W-1:0];
                REG_WINDOW_LENGTH: cfg_reg.window_length <= pwdata[WLEN_W-1:0];
                REG_ENERGY_RATIO:  cfg_reg.energy_ratio  <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FILTER_ENABLE: prdata = APB_DATA_W'(cfg_reg.filter_enable);
            REG_FILTER_ALPHA:  prdata = APB_DATA_W'(cfg_reg.filter_alpha);
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(cfg_reg.window_length);
            REG_ENERGY_RATIO:  prdata = APB_DATA_W'(cfg_reg.energy_ratio);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/erv_ctrl.sv
// sequencer for per-sample steps and the end-of-buffer decision
`default_nettype none
`include "assert_macros.svh"
module erv_ctrl import erv_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILT    = 3'd1;
    localparam logic [2:0] ST_ACC     = 3'd2;
    localparam logic [2:0] ST_EVMUL   = 3'd3;
    localparam logic [2:0] ST_EVSCALE = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_accept;
                if (in_accept)
                    state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.last ? ST_EVMUL : ST_IDLE;
            end
            ST_EVMUL:
            begin
                cmd.ev_mul = 1'b1;
                state_next = ST_EVSCALE;
            end
            ST_EVSCALE:
            begin
                cmd.ev_scale = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the previous result beat has left
                cmd.finish = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_accept_starts, in_accept, state_reg == ST_FILT, "accepted beat not started")
    `ASSERT_IMPL(a_no_overwrite, cmd.finish, out_free, "result written over pending beat")
    `ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_reg, "finished result not shown")

endmodule
`default_nettype wire

// File: rtl/erv_dp.sv
// filter, energy sums, window ring and decision arithmetic
`default_nettype none
`include "assert_macros.svh"
module erv_dp import erv_pkg::*; #(
    parameter int MAX_WINDOW  = 16384,
    parameter int MAX_SAMPLES = 1048576
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfg_t                       cfg,
    input  wire dp_cmd_t                    cmd,
    output dp_sts_t                         sts,
    input  wire logic signed [SAMPLE_W-1:0] audio_sample,
    input  wire logic                       last_sample,
    output logic                            voice_active,
    output logic                            buffer_long_enough
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int WIN_W  = PTR_W + 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES);
    localparam int WE_W   = PTR_W + MAG_W + 1;
    localparam int WLX_W  = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;
    localparam int CNX_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int L_W    = WE_W + CNT_W;
    localparam int P_W    = TOTAL_W + RATIO_W;
    localparam int R_W    = P_W + WIN_W;
    localparam int CMP_W  = ((L_W + 8) > R_W) ? (L_W + 8) : R_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES - 1);

    // buffer state
    logic signed [SAMPLE_W-1:0] pi_reg;
    logic signed [FILT_W-1:0]   fo_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [WE_W-1:0]            we_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       last_reg;

    // working registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [MAG_W-1:0]           ring_rd_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [L_W-1:0]             l_reg;
    logic [P_W-1:0]             p_reg;
    logic [R_W-1:0]             r_reg;
    logic                       voice_reg;
    logic                       long_reg;

    logic [MAG_W-1:0] ring_mem [MAX_WINDOW];

    logic [WLX_W-1:0]           wl_ext;
    logic [WLX_W-1:0]           w_x;
    logic [WIN_W-1:0]           w_eff;
    logic [PTR_W-1:0]           ptr_eff;
    logic [WIN_W-1:0]           ptr_inc;
    logic [PTR_W-1:0]           ptr_adv;
    logic [CNX_W-1:0]           cnt_x;
    logic [CNX_W-1:0]           w_cx;
    logic                       full_win;
    logic                       longer;
    logic signed [FILT_W:0]     diff;
    logic signed [ALPHA_W:0]    alpha_s;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W:0]     rnd;
    logic signed [PROD_W-FRAC_W:0] quo;
    logic signed [FILT_W-1:0]   y_filt;
    logic signed [FILT_W-1:0]   y;
    logic [FILT_W-1:0]          y_abs;
    logic [MAG_W-1:0]           mag;
    logic [TOTAL_W:0]           total_sum;
    logic [TOTAL_W-1:0]         total_next;
    logic [WE_W-1:0]            we_drop;
    logic [CMP_W-1:0]           lhs;
    logic [CMP_W-1:0]           rhs;

    assign sts.last = last_reg;

    // window length limited to 1..MAX_WINDOW
    always_comb
    begin
        wl_ext = WLX_W'(cfg.window_length);
        if (wl_ext == '0)
            w_x = WLX_W'(1);
        else if (wl_ext > WLX_W'(MAX_WINDOW))
            w_x = WLX_W'(MAX_WINDOW);
        else
            w_x = wl_ext;
        w_eff = w_x[WIN_W-1:0];
    end

    assign ptr_eff  = ({1'b0, ptr_reg} >= w_eff) ? '0 : ptr_reg;
    assign ptr_inc  = {1'b0, ptr_eff} + WIN_W'(1);
    assign ptr_adv  = (ptr_inc >= w_eff) ? '0 : ptr_inc[PTR_W-1:0];
    assign cnt_x    = CNX_W'(cnt_reg);
    assign w_cx     = CNX_W'(w_eff);
    assign full_win = (cnt_x >= w_cx);
    assign longer   = (cnt_x > w_cx);

    // high-pass filter product
    assign diff    = (FILT_W+1)'(fo_reg) + (FILT_W+1)'(x_reg) - (FILT_W+1)'(pi_reg);
    assign alpha_s = {1'b0, cfg.filter_alpha};
    assign prod_c  = diff * alpha_s;

    // round to nearest, ties up, then floor by 2^16
    always_comb
    begin
        rnd = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(32768);
        quo = rnd[PROD_W:FRAC_W];
        if (quo > FILT_MAX)
            y_filt = FILT_W'(FILT_MAX);
        else if (quo < FILT_MIN)
            y_filt = FILT_W'(FILT_MIN);
        else
            y_filt = quo[FILT_W-1:0];
        if (cfg.filter_enable && (cnt_reg != '0))
            y = y_filt;
        else
            y = FILT_W'(x_reg);
        y_abs = y[FILT_W-1] ? (~y + 1'b1) : y;
        mag   = (y_abs > FILT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : y_abs[MAG_W-1:0];
        total_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(mag);
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        we_drop    = (we_reg >= WE_W'(ring_rd_reg)) ? (we_reg - WE_W'(ring_rd_reg)) : '0;
    end

    assign lhs = CMP_W'({l_reg, 8'h00});
    assign rhs = CMP_W'(r_reg);

    // ring of magnitudes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            ring_rd_reg <= ring_mem[ptr_eff];
        if (cmd.acc)
            ring_mem[ptr_eff] <= mag;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= audio_sample;
        if (cmd.filt)
            prod_reg <= prod_c;
        if (cmd.ev_mul)
        begin
            l_reg <= L_W'(we_reg) * L_W'(cnt_reg);
            p_reg <= P_W'(total_reg) * P_W'(cfg.energy_ratio);
        end
        if (cmd.ev_scale)
            r_reg <= R_W'(p_reg) * R_W'(w_eff);
        if (cmd.finish)
        begin
            voice_reg <= longer && (lhs > rhs);
            long_reg  <= longer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg    <= '0;
            fo_reg    <= '0;
            total_reg <= '0;
            we_reg    <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                last_reg <= last_sample;
            if (cmd.filt)
            begin
                if (full_win)
                    we_reg <= we_drop;
            end
            else if (cmd.acc)
            begin
                pi_reg    <= x_reg;
                fo_reg    <= y;
                total_reg <= total_next;
                we_reg    <= we_reg + WE_W'(mag);
                ptr_reg   <= ptr_adv;
                if (cnt_reg < CNT_MAX)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.finish)
            begin
                pi_reg    <= '0;
                fo_reg    <= '0;
                total_reg <= '0;
                we_reg    <= '0;
                ptr_reg   <= '0;
                cnt_reg   <= '0;
            end
        end
    end

    assign voice_active       = voice_reg;
    assign buffer_long_enough = long_reg;

    `ASSERT_NEXT(a_clear_after_finish, cmd.finish, cnt_reg == '0 && total_reg == '0, "not cleared")
    `ASSERT_NEXT(a_total_monotone, cmd.acc, total_reg >= $past(total_reg), "total energy fell")
    `ASSERT_NEXT(a_count_steps, cmd.acc && cnt_reg < CNT_MAX, cnt_reg != $past(cnt_reg), "count stuck")

endmodule
`default_nettype wire

// File: rtl/energy_ratio_voice_detector.sv
// result beat is shown once the last sample and the decision are through
// one sample at a time: ring read on accept, filter multiply, then update
// the decision multiplies, scales, then compares once the output is free
// reset: configuration returns to defaults, sums, pointer and count clear;
// the ring is not cleared and is only read where already written
`default_nettype none
module energy_ratio_voice_detector import erv_pkg::*; #(
    parameter int MAX_WINDOW  = 16384,
    parameter int MAX_SAMPLES = 1048576
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    erv_in_if.sink                     sample_ch,
    erv_out_if.source                  result_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;
    logic    out_valid;
    logic    voice_active;
    logic    buffer_long_enough;

    erv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    erv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    erv_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .sts                (sts),
        .audio_sample       (sample_ch.audio_sample),
        .last_sample        (sample_ch.last_sample),
        .voice_active       (voice_active),
        .buffer_long_enough (buffer_long_enough)
    );

    assign sample_ch.ready              = in_ready;
    assign result_ch.valid              = out_valid;
    assign result_ch.voice_active       = voice_active;
    assign result_ch.buffer_long_enough = buffer_long_enough;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking bench for the energy ratio voice detector: sample stream in, verdicts out
`timescale 1ns / 1ps
module tb_top;
    import erv_pkg::*;

    localparam int MAX_WINDOW     = 16384;
    localparam int MAX_SAMPLES    = 1048576;
    localparam int RANDOM_SAMPLES = 900;
    localparam int DRAIN_CYCLES   = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int FULL_SCALE     = 32768;
    localparam int Q8_ONE         = 256;

    typedef struct {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       lst;
        int unsigned                pause;
        bit                         hold;
    } pcm_beat_t;

    typedef struct packed {
        logic voice;
        logic long_enough;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    erv_in_if  smp_if ();
    erv_out_if res_if ();

    energy_ratio_voice_detector #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_if),
        .result_ch (res_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // detector model state
    cfg_t                     det_cfg = '{RST_FILTER_ENABLE, RST_FILTER_ALPHA,
                                          RST_WINDOW_LENGTH, RST_ENERGY_RATIO};
    logic signed [SAMPLE_W-1:0] prev_x  = '0;
    logic signed [FILT_W-1:0]   prev_y  = '0;
    logic [TOTAL_W-1:0]         sum_all = '0;
    logic [30:0]                sum_win = '0;
    logic [MAG_W-1:0]           mag_ring [MAX_WINDOW];
    int unsigned                ring_at = 0;
    int unsigned                n_seen  = 0;

    pcm_beat_t   feed_q[$];
    verdict_t    verdict_q[$];

    logic        beat_taken = 1'b0;
    bit          gap_armed  = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    bit          out_calm   = 1'b0;
    int unsigned quiet_cycles = 0;

    int unsigned err_count = 0;
    int unsigned n_samples = 0;
    int unsigned n_buffers = 0;
    int unsigned n_results = 0;
    int unsigned n_voice   = 0;
    int unsigned n_long    = 0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // filter, energies and the end-of-buffer decision for one accepted sample
    function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] x, logic lst);
        int unsigned              w;
        longint                   d;
        longint                   t;
        longint                   q;
        logic signed [FILT_W-1:0] y;
        int                       yi;
        int unsigned              mag;
        int unsigned              old;
        logic [TOTAL_W:0]         acc;
        logic [127:0]             lhs;
        logic [127:0]             rhs;
        verdict_t                 v;

        w = det_cfg.window_length;
        if (w == 0)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;

        if (det_cfg.filter_enable && n_seen != 0)
        begin
            d = longint'(prev_y) + longint'(x) - longint'(prev_x);
            t = d * longint'(det_cfg.filter_alpha) + (longint'(1) <<< (FRAC_W - 1));
            q = t >>> FRAC_W;
            if (q > FILT_MAX)
                q = FILT_MAX;
            if (q < FILT_MIN)
                q = FILT_MIN;
            y = q[FILT_W-1:0];
        end
        else
        begin
            y = x;
        end
        prev_x = x;
        prev_y = y;

        yi  = y;
        mag = (yi < 0) ? -yi : yi;
        if (mag > MAG_MAX)
            mag = MAG_MAX;

        acc = sum_all + mag;
        if (acc > {TOTAL_W{1'b1}})
            sum_all = '1;
        else
            sum_all = acc[TOTAL_W-1:0];

        if (ring_at >= w)
            ring_at = 0;
        if (n_seen >= w)
        begin
            old = mag_ring[ring_at];
            if (sum_win >= old)
                sum_win = sum_win - old;
            else
                sum_win = '0;
        end
        sum_win = sum_win + mag;
        mag_ring[ring_at] = mag[MAG_W-1:0];
        ring_at = (ring_at + 1 >= w) ? 0 : ring_at + 1;

        if (n_seen < MAX_SAMPLES - 1)
            n_seen++;
        n_samples++;

        if (lst)
        begin
            v.long_enough = (n_seen > w);
            v.voice       = 1'b0;
            if (v.long_enough)
            begin
                lhs = 128'(sum_win) * 128'(n_seen) * 128'(Q8_ONE);
                rhs = 128'(sum_all) * 128'(w) * 128'(det_cfg.energy_ratio);
                v.voice = (lhs > rhs);
            end
            verdict_q.push_back(v);
            n_buffers++;
            if (v.voice)
                n_voice++;
            if (v.long_enough)
                n_long++;
            prev_x  = '0;
            prev_y  = '0;
            sum_all = '0;
            sum_win = '0;
            ring_at = 0;
            n_seen  = 0;
        end
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        logic      nv;
        pcm_beat_t nb;
        if (rst_n)
        begin
            nv = smp_if.valid && !beat_taken;
            if (!nv && feed_q.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left  = feed_q[0].pause;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (!(feed_q[0].hold && verdict_q.size() != 0))
                begin
                    nb = feed_q.pop_front();
                    smp_if.audio_sample <= nb.pcm;
                    smp_if.last_sample  <= nb.lst;
                    gap_armed = 1'b0;
                    nv = 1'b1;
                end
            end
            smp_if.valid <= nv;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0 && !out_calm && $urandom_range(0, 99) < 12)
                stall_left = pick_gap();
            if (stall_left != 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // monitor: predict on sample beats, check result beats
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            beat_taken <= smp_if.valid && smp_if.ready;
            if (smp_if.valid && smp_if.ready)
                absorb_sample(smp_if.audio_sample, smp_if.last_sample);
            if (res_if.valid && res_if.ready)
            begin
                n_results++;
                if (verdict_q.size() == 0)
                begin
                    flag_mismatch($sformatf("result beat %0d with no verdict pending", n_results));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (res_if.voice_active !== want.voice)
                        flag_mismatch($sformatf("result %0d voice_active got %b want %b",
                                                n_results, res_if.voice_active, want.voice));
                    if (res_if.buffer_long_enough !== want.long_enough)
                        flag_mismatch($sformatf("result %0d buffer_long_enough got %b want %b",
                                                n_results, res_if.buffer_long_enough,
                                                want.long_enough));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d verdicts pending",
                         quiet_cycles, verdict_q.size());
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [APB_DATA_W-1:0] cfg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_FILTER_ENABLE: return APB_DATA_W'(det_cfg.filter_enable);
            REG_FILTER_ALPHA:  return APB_DATA_W'(det_cfg.filter_alpha);
            REG_WINDOW_LENGTH: return APB_DATA_W'(det_cfg.window_length);
            REG_ENERGY_RATIO:  return APB_DATA_W'(det_cfg.energy_ratio);
            default:           return '0;
        endcase
    endfunction

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== cfg_value(idx))
            flag_mismatch($sformatf("register %0d reads %0h want %0h", idx, rd, cfg_value(idx)));
    endtask

    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_FILTER_ENABLE: det_cfg.filter_enable = value[0];
            REG_FILTER_ALPHA:  det_cfg.filter_alpha  = value[ALPHA_W-1:0];
            REG_WINDOW_LENGTH: det_cfg.window_length = value[WLEN_W-1:0];
            REG_ENERGY_RATIO:  det_cfg.energy_ratio  = value[RATIO_W-1:0];
            default: ;
        endcase
        check_reg(idx);
    endtask

    // wait until the detector has nothing in flight
    task automatic settle();
        while (feed_q.size() != 0 || smp_if.valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        out_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic push_beat(input logic signed [SAMPLE_W-1:0] pcm, input logic lst);
        pcm_beat_t b;
        b.pcm   = pcm;
        b.lst   = lst;
        b.pause = pick_gap();
        b.hold  = 1'b0;
        feed_q.push_back(b);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_pcm(int amp);
        int v;
        if (amp >= FULL_SCALE)
            v = $urandom;
        else
            v = int'($urandom_range(0, 2 * amp)) - amp;
        return v[SAMPLE_W-1:0];
    endfunction

    // one buffer: quiet body, loud trailing part of length tail
    task automatic queue_buffer(input int len, input int quiet, input int loud,
                                input int tail, input bit hold_first);
        pcm_beat_t b;
        bit        calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
        begin
            b.pcm   = draw_pcm((k >= len - tail) ? loud : quiet);
            b.lst   = (k == len - 1);
            b.pause = calm ? 0 : pick_gap();
            b.hold  = hold_first && (k == 0);
            feed_q.push_back(b);
        end
    endtask

    initial
    begin
        int          random_beats;
        int          win;
        int          w_eff;
        int          nbuf;
        int          len;
        int          quiet;
        int          loud;
        bit          first_phase;

        smp_if.valid        = 1'b0;
        smp_if.audio_sample = '0;
        smp_if.last_sample  = 1'b0;
        res_if.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_reg(REG_FILTER_ENABLE);
        check_reg(REG_FILTER_ALPHA);
        check_reg(REG_WINDOW_LENGTH);
        check_reg(REG_ENERGY_RATIO);

        // reset settings: a buffer much shorter than the default window
        push_beat(16'sd100, 1'b0);
        push_beat(-16'sd100, 1'b0);
        push_beat(16'sd5, 1'b1);
        settle();

        // tiny window, filter passing nearly everything, ratio of one
        set_reg(REG_WINDOW_LENGTH, 4);
        set_reg(REG_FILTER_ALPHA, 32'hFFFF);
        set_reg(REG_ENERGY_RATIO, Q8_ONE);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(-16'sd1, 1'b0);
        push_beat(16'sd1, 1'b0);
        push_beat(16'sh7FFF, 1'b1);
        // single-sample buffer, passes the filter unchanged
        push_beat(16'sh8000, 1'b1);
        // buffer exactly as long as the window
        push_beat(16'sd1000, 1'b0);
        push_beat(-16'sd2000, 1'b0);
        push_beat(16'sd3000, 1'b0);
        push_beat(-16'sd4000, 1'b1);
        // one sample longer than the window
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(16'sh7FFF, 1'b1);
        settle();

        // zero window acts as one, filter bypassed, zero ratio
        set_reg(REG_WINDOW_LENGTH, 0);
        set_reg(REG_FILTER_ENABLE, 0);
        set_reg(REG_FILTER_ALPHA, 0);
        set_reg(REG_ENERGY_RATIO, 0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(16'sh7FFF, 1'b1);

        random_beats = 0;
        first_phase  = 1'b1;
        while (random_beats < RANDOM_SAMPLES)
        begin
            settle();
            set_reg(REG_FILTER_ENABLE, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:       set_reg(REG_FILTER_ALPHA, 0);
                1:       set_reg(REG_FILTER_ALPHA, 32'hFFFF);
                default: set_reg(REG_FILTER_ALPHA, $urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       win = 0;
                1:       win = 1;
                default: win = $urandom_range(2, 24);
            endcase
            set_reg(REG_WINDOW_LENGTH, win);
            case ($urandom_range(0, 7))
                0:       set_reg(REG_ENERGY_RATIO, 0);
                1:       set_reg(REG_ENERGY_RATIO, 32'hFFFF);
                2:       set_reg(REG_ENERGY_RATIO, Q8_ONE);
                default: set_reg(REG_ENERGY_RATIO, $urandom_range(64, 768));
            endcase
            w_eff = (win == 0) ? 1 : win;
            nbuf  = $urandom_range(2, 6);
            for (int n = 0; n < nbuf; n++)
            begin
                case ($urandom_range(0, 4))
                    0:       len = w_eff;
                    1:       len = w_eff + 1;
                    default: len = $urandom_range(1, 2 * w_eff + 8);
                endcase
                case ($urandom_range(0, 3))
                    0:       quiet = 0;
                    1:       quiet = 40;
                    2:       quiet = 1500;
                    default: quiet = FULL_SCALE;
                endcase
                case ($urandom_range(0, 3))
                    0:       loud = 0;
                    1:       loud = 3000;
                    2:       loud = 20000;
                    default: loud = FULL_SCALE;
                endcase
                // the second buffer of the first phase waits for the first verdict
                queue_buffer(len, quiet, loud, $urandom_range(0, len),
                             (first_phase && n == 1) || ($urandom_range(0, 6) == 0));
                random_beats += len;
            end
            first_phase = 1'b0;
        end
        settle();

        // oversized window clamps to the ring depth
        set_reg(REG_WINDOW_LENGTH, 32767);
        set_reg(REG_FILTER_ENABLE, 1);
        set_reg(REG_FILTER_ALPHA, $urandom_range(30000, 65535));
        set_reg(REG_ENERGY_RATIO, RST_ENERGY_RATIO);
        queue_buffer(150, 2000, 30000, 40, 1'b0);
        settle();

        set_reg(REG_WINDOW_LENGTH, MAX_WINDOW);
        queue_buffer(150, 500, FULL_SCALE, 50, 1'b0);
        settle();

        $display("covered %0d samples in %0d buffers: %0d voice, %0d no voice,",
                 n_samples, n_buffers, n_voice, n_long - n_voice);
        $display("%0d buffers not longer than the window", n_buffers - n_long);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/erv_pkg.sv
rtl/erv_if.sv
rtl/erv_regs.sv
rtl/erv_ctrl.sv
rtl/erv_dp.sv
rtl/energy_ratio_voice_detector.sv
tb/tb_top.sv
